// File: hdl/lbct_pkg.sv
// Shared constants and result codes for the block cache tag store.
// Used by lbct_cell, lbct_ctrl and lru_block_cache_tags_core.
package lbct_pkg;

    localparam int LEN_W      = 25;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 4;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT         = 3'd0,
        ST_MISS        = 3'd1,
        ST_FILL_STORED = 3'd2,
        ST_FILL_FAILED = 3'd3,
        ST_FILL_NOPEND = 3'd4
    } t_status;

endpackage

// File: hdl/lbct_cell.sv
// One slot of the tag store: tag, valid, length and stamp of a single way.
// Passes the scan record to its neighbor every cycle. Depends on lbct_pkg.
module lbct_cell #(
    parameter int CELL_IDX   = 0,
    parameter int BLOCK_BITS = 26,
    parameter int STAMP_BITS = 32,
    parameter int IDX_W      = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [BLOCK_BITS+2*IDX_W+STAMP_BITS+lbct_pkg::LEN_W+1:0] i_scan,
    output logic [BLOCK_BITS+2*IDX_W+STAMP_BITS+lbct_pkg::LEN_W+1:0] o_scan,
    input  logic [IDX_W+BLOCK_BITS+lbct_pkg::LEN_W+STAMP_BITS+2:0]   i_wr
);
    import lbct_pkg::*;

    typedef struct packed {
        logic                  active;
        logic [BLOCK_BITS-1:0] blk;
        logic                  hit;
        logic [IDX_W-1:0]      hit_idx;
        logic [LEN_W-1:0]      hit_len;
        logic [STAMP_BITS-1:0] min_stamp;
        logic [IDX_W-1:0]      min_idx;
    } t_scan;

    typedef struct packed {
        logic                  en_fill;
        logic                  en_stamp;
        logic                  en_clear;
        logic [IDX_W-1:0]      idx;
        logic [BLOCK_BITS-1:0] tag;
        logic [LEN_W-1:0]      len;
        logic [STAMP_BITS-1:0] stamp;
    } t_slot_wr;

    t_scan    w_in;
    t_scan    n_scan;
    t_scan    r_scan;
    t_slot_wr w_wr;
    logic     w_sel;

    logic [BLOCK_BITS-1:0] r_tag;
    logic                  r_valid;
    logic [LEN_W-1:0]      r_len;
    logic [STAMP_BITS-1:0] r_stamp;

    assign w_in   = t_scan'(i_scan);
    assign w_wr   = t_slot_wr'(i_wr);
    assign o_scan = r_scan;
    assign w_sel  = (w_wr.idx == IDX_W'(CELL_IDX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag   <= '0;
            r_valid <= 1'b0;
            r_len   <= '0;
            r_stamp <= '0;
        end else if (w_sel) begin
            if (w_wr.en_fill) begin
                r_tag   <= w_wr.tag;
                r_valid <= 1'b1;
                r_len   <= w_wr.len;
                r_stamp <= w_wr.stamp;
            end
            if (w_wr.en_stamp) begin
                r_stamp <= w_wr.stamp;
            end
            if (w_wr.en_clear) begin
                r_valid <= 1'b0;
            end
        end
    end

    // The first valid match wins; a strictly smaller stamp takes over the victim,
    // so ties keep the lower index that passed earlier in the chain.
    always_comb begin
        n_scan = w_in;
        if (w_in.active) begin
            if (!w_in.hit && r_valid && (r_tag == w_in.blk)) begin
                n_scan.hit     = 1'b1;
                n_scan.hit_idx = IDX_W'(CELL_IDX);
                n_scan.hit_len = r_len;
            end
            if (r_stamp < w_in.min_stamp) begin
                n_scan.min_stamp = r_stamp;
                n_scan.min_idx   = IDX_W'(CELL_IDX);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.active <= 1'b0;
        end else begin
            r_scan.active <= n_scan.active;
        end
        r_scan.blk       <= n_scan.blk;
        r_scan.hit       <= n_scan.hit;
        r_scan.hit_idx   <= n_scan.hit_idx;
        r_scan.hit_len   <= n_scan.hit_len;
        r_scan.min_stamp <= n_scan.min_stamp;
        r_scan.min_idx   <= n_scan.min_idx;
    end

endmodule

// File: hdl/lbct_ctrl.sv
// Sequencer of the tag store: accepts items, launches the scan record into
// the cell chain, decides hit or victim, issues slot writes, holds the result.
// Depends on lbct_pkg.
module lbct_ctrl #(
    parameter int BLOCK_BITS = 26,
    parameter int STAMP_BITS = 32,
    parameter int IDX_W      = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_action,
    input  logic [BLOCK_BITS-1:0]            i_block_number,
    input  logic                             i_fill_ok,
    input  logic [lbct_pkg::LEN_W-1:0]       i_fill_length,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [lbct_pkg::STATUS_W-1:0]    o_status,
    output logic [lbct_pkg::SLOT_OUT_W-1:0]  o_slot_index,
    output logic [lbct_pkg::LEN_W-1:0]       o_valid_length,
    output logic [BLOCK_BITS+2*IDX_W+STAMP_BITS+lbct_pkg::LEN_W+1:0] o_launch,
    input  logic [BLOCK_BITS+2*IDX_W+STAMP_BITS+lbct_pkg::LEN_W+1:0] i_chain_end,
    output logic [IDX_W+BLOCK_BITS+lbct_pkg::LEN_W+STAMP_BITS+2:0]   o_wr
);
    import lbct_pkg::*;

    typedef struct packed {
        logic                  active;
        logic [BLOCK_BITS-1:0] blk;
        logic                  hit;
        logic [IDX_W-1:0]      hit_idx;
        logic [LEN_W-1:0]      hit_len;
        logic [STAMP_BITS-1:0] min_stamp;
        logic [IDX_W-1:0]      min_idx;
    } t_scan;

    typedef struct packed {
        logic                  en_fill;
        logic                  en_stamp;
        logic                  en_clear;
        logic [IDX_W-1:0]      idx;
        logic [BLOCK_BITS-1:0] tag;
        logic [LEN_W-1:0]      len;
        logic [STAMP_BITS-1:0] stamp;
    } t_slot_wr;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    t_state                r_state,      n_state;
    logic [STAMP_BITS-1:0] r_clock,      n_clock;
    logic                  r_pend,       n_pend;
    logic [IDX_W-1:0]      r_pend_slot,  n_pend_slot;
    logic [BLOCK_BITS-1:0] r_pend_block, n_pend_block;
    t_status               r_res_status, n_res_status;
    logic [IDX_W-1:0]      r_res_idx,    n_res_idx;
    logic [LEN_W-1:0]      r_res_len,    n_res_len;
    logic                  r_out_valid,  n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [IDX_W-1:0]      r_out_idx,    n_out_idx;
    logic [LEN_W-1:0]      r_out_len,    n_out_len;

    t_scan                 w_launch;
    t_scan                 w_end;
    t_slot_wr              w_wr;
    logic                  w_accept;
    logic [STAMP_BITS-1:0] w_next_stamp;

    assign o_ready        = (r_state == S_IDLE);
    assign w_accept       = i_valid && o_ready;
    assign w_end          = t_scan'(i_chain_end);
    assign w_next_stamp   = r_clock + STAMP_BITS'(1);
    assign o_launch       = w_launch;
    assign o_wr           = w_wr;
    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_slot_index   = SLOT_OUT_W'(r_out_idx);
    assign o_valid_length = r_out_len;

    always_comb begin
        w_launch           = '0;
        w_launch.active    = w_accept && !i_action;
        w_launch.blk       = i_block_number;
        w_launch.min_stamp = '1;

        w_wr         = '0;
        n_state      = r_state;
        n_clock      = r_clock;
        n_pend       = r_pend;
        n_pend_slot  = r_pend_slot;
        n_pend_block = r_pend_block;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        n_res_len    = r_res_len;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_idx    = r_out_idx;
        n_out_len    = r_out_len;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (!i_action) begin
                        // A new lookup abandons any miss still waiting for its fill.
                        n_pend  = 1'b0;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FIN;
                        if (!r_pend) begin
                            n_res_status = ST_FILL_NOPEND;
                            n_res_idx    = '0;
                            n_res_len    = '0;
                        end else begin
                            n_pend    = 1'b0;
                            n_res_idx = r_pend_slot;
                            if (i_fill_ok) begin
                                w_wr.en_fill = 1'b1;
                                w_wr.idx     = r_pend_slot;
                                w_wr.tag     = r_pend_block;
                                w_wr.len     = i_fill_length;
                                w_wr.stamp   = w_next_stamp;
                                n_clock      = w_next_stamp;
                                n_res_status = ST_FILL_STORED;
                                n_res_len    = i_fill_length;
                            end else begin
                                n_res_status = ST_FILL_FAILED;
                                n_res_len    = '0;
                            end
                        end
                    end
                end
            end
            S_SCAN: begin
                if (w_end.active) begin
                    n_state = S_FIN;
                    if (w_end.hit) begin
                        w_wr.en_stamp = 1'b1;
                        w_wr.idx      = w_end.hit_idx;
                        w_wr.stamp    = w_next_stamp;
                        n_clock       = w_next_stamp;
                        n_res_status  = ST_HIT;
                        n_res_idx     = w_end.hit_idx;
                        n_res_len     = w_end.hit_len;
                    end else begin
                        w_wr.en_clear = 1'b1;
                        w_wr.idx      = w_end.min_idx;
                        n_pend        = 1'b1;
                        n_pend_slot   = w_end.min_idx;
                        n_pend_block  = w_end.blk;
                        n_res_status  = ST_MISS;
                        n_res_idx     = w_end.min_idx;
                        n_res_len     = '0;
                    end
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_idx    = r_res_idx;
                    n_out_len    = r_res_len;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_clock      <= '0;
            r_pend       <= 1'b0;
            r_pend_slot  <= '0;
            r_pend_block <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clock      <= n_clock;
            r_pend       <= n_pend;
            r_pend_slot  <= n_pend_slot;
            r_pend_block <= n_pend_block;
            r_out_valid  <= n_out_valid;
        end
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        r_res_len    <= n_res_len;
        r_out_status <= n_out_status;
        r_out_idx    <= n_out_idx;
        r_out_len    <= n_out_len;
    end

endmodule

// File: hdl/lru_block_cache_tags_core.sv
// Tag and LRU replacement store of a fully associative cache of decoded blocks.
// Channels: input item (i_valid/o_ready) with action, block number, fill outcome
// and fill length; result item (o_valid/i_ready) with status, slot and length.
// Every item gives exactly one result. A lookup walks a scan record through a
// chain of SLOTS cells, one cell per cycle, collecting the first tag match and
// the oldest stamp; the controller waits in S_SCAN until the record leaves the
// last cell, then S_FIN moves the result to the output register and the next
// item is taken in S_IDLE. A fill touches only the pending slot; it goes from
// S_IDLE to S_FIN, which moves its result out before the next item is taken.
// One item is in work at a time; the next is accepted once the result has
// moved to the output register, so a result may wait there while the next
// item runs. If the receiver stalls with a result still waiting, the finished
// result is held inside and no new item is taken until the output frees.
// Reset (synchronous, active low) empties all slots, zeroes stamps, tags,
// lengths and the stamp clock, and drops any pending miss; the block is ready
// as soon as reset is released.
// Depends on lbct_pkg, lbct_cell and lbct_ctrl.
module lru_block_cache_tags_core #(
    parameter int SLOTS      = 16,
    parameter int BLOCK_BITS = 26,
    parameter int STAMP_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_action,
    input  logic [BLOCK_BITS-1:0]            i_block_number,
    input  logic                             i_fill_ok,
    input  logic [lbct_pkg::LEN_W-1:0]       i_fill_length,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [lbct_pkg::STATUS_W-1:0]    o_status,
    output logic [lbct_pkg::SLOT_OUT_W-1:0]  o_slot_index,
    output logic [lbct_pkg::LEN_W-1:0]       o_valid_length
);
    import lbct_pkg::*;

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SCAN_W = BLOCK_BITS + 2 * IDX_W + STAMP_BITS + LEN_W + 2;
    localparam int WR_W   = IDX_W + BLOCK_BITS + LEN_W + STAMP_BITS + 3;

    logic [SCAN_W-1:0] w_scan [SLOTS+1];
    logic [WR_W-1:0]   w_wr;

    lbct_ctrl #(
        .BLOCK_BITS (BLOCK_BITS),
        .STAMP_BITS (STAMP_BITS),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_block_number (i_block_number),
        .i_fill_ok      (i_fill_ok),
        .i_fill_length  (i_fill_length),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_slot_index   (o_slot_index),
        .o_valid_length (o_valid_length),
        .o_launch       (w_scan[0]),
        .i_chain_end    (w_scan[SLOTS]),
        .o_wr           (w_wr)
    );

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        lbct_cell #(
            .CELL_IDX   (g),
            .BLOCK_BITS (BLOCK_BITS),
            .STAMP_BITS (STAMP_BITS),
            .IDX_W      (IDX_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_scan  (w_scan[g]),
            .o_scan  (w_scan[g+1]),
            .i_wr    (w_wr)
        );
    end

endmodule
